// File: hw/rtl/sm83_pkg.sv
// Package for the SM83 opcode predecoder: mnemonic codes, flag effect codes
// and the decode entry type with its table functions. No dependencies.
package sm83_pkg;

   typedef enum logic [5:0] {
      MN_NOP = 6'd0, MN_LD = 6'd1, MN_INC = 6'd2, MN_DEC = 6'd3, MN_RLCA = 6'd4,
      MN_ADD = 6'd5, MN_RRCA = 6'd6, MN_STOP = 6'd7, MN_RLA = 6'd8, MN_JR = 6'd9,
      MN_RRA = 6'd10, MN_DAA = 6'd11, MN_CPL = 6'd12, MN_SCF = 6'd13, MN_CCF = 6'd14,
      MN_HALT = 6'd15, MN_ADC = 6'd16, MN_SUB = 6'd17, MN_SBC = 6'd18, MN_AND = 6'd19,
      MN_XOR = 6'd20, MN_OR = 6'd21, MN_CP = 6'd22, MN_RET = 6'd23, MN_POP = 6'd24,
      MN_JP = 6'd25, MN_CALL = 6'd26, MN_PUSH = 6'd27, MN_RST = 6'd28, MN_RETI = 6'd29,
      MN_LDH = 6'd30, MN_DI = 6'd31, MN_EI = 6'd32, MN_RLC = 6'd33, MN_RRC = 6'd34,
      MN_RL = 6'd35, MN_RR = 6'd36, MN_SLA = 6'd37, MN_SRA = 6'd38, MN_SWAP = 6'd39,
      MN_SRL = 6'd40, MN_BIT = 6'd41, MN_RES = 6'd42, MN_SET = 6'd43,
      MN_UNKNOWN = 6'd44
   } mnemonic_type;

   localparam logic [1:0] FX_KEEP = 2'd0;
   localparam logic [1:0] FX_CLR  = 2'd1;
   localparam logic [1:0] FX_SET  = 2'd2;
   localparam logic [1:0] FX_CALC = 2'd3;

   typedef struct packed {
      logic [1:0] z;
      logic [1:0] n;
      logic [1:0] h;
      logic [1:0] c;
   } flags_type;

   typedef struct packed {
      mnemonic_type mn;
      logic [1:0]   len;
      logic [4:0]   base;
      logic [4:0]   taken;
      flags_type    fl;
   } entry_type;

   localparam flags_type F_NO    = '{FX_KEEP, FX_KEEP, FX_KEEP, FX_KEEP};
   localparam flags_type F_INC   = '{FX_CALC, FX_CLR, FX_CALC, FX_KEEP};
   localparam flags_type F_DEC   = '{FX_CALC, FX_SET, FX_CALC, FX_KEEP};
   localparam flags_type F_ROTA  = '{FX_CLR, FX_CLR, FX_CLR, FX_CALC};
   localparam flags_type F_ADDHL = '{FX_KEEP, FX_CLR, FX_CALC, FX_CALC};
   localparam flags_type F_DAA   = '{FX_CALC, FX_KEEP, FX_CALC, FX_CALC};
   localparam flags_type F_CPL   = '{FX_KEEP, FX_SET, FX_SET, FX_KEEP};
   localparam flags_type F_SCF   = '{FX_KEEP, FX_CLR, FX_CLR, FX_SET};
   localparam flags_type F_CCF   = '{FX_KEEP, FX_CLR, FX_CLR, FX_CALC};
   localparam flags_type F_ALUA  = '{FX_CALC, FX_CLR, FX_CALC, FX_CALC};
   localparam flags_type F_ALUS  = '{FX_CALC, FX_SET, FX_CALC, FX_CALC};
   localparam flags_type F_AND   = '{FX_CALC, FX_CLR, FX_SET, FX_CLR};
   localparam flags_type F_OR    = '{FX_CALC, FX_CLR, FX_CLR, FX_CLR};
   localparam flags_type F_SP    = '{FX_CLR, FX_CLR, FX_CALC, FX_CALC};
   localparam flags_type F_SHIFT = '{FX_CALC, FX_CLR, FX_CLR, FX_CALC};
   localparam flags_type F_SWAP  = '{FX_CALC, FX_CLR, FX_CLR, FX_CLR};
   localparam flags_type F_BIT   = '{FX_CALC, FX_CLR, FX_SET, FX_KEEP};

   localparam logic [7:0] OP_PREFIX = 8'hCB;
   localparam logic [7:0] OP_HALT   = 8'h76;
   localparam logic [2:0] REG_HL    = 3'd6;
   localparam logic [2:0] GRP_SWAP  = 3'd6;

   function automatic entry_type mk(mnemonic_type m, logic [1:0] l, logic [4:0] b,
                                    logic [4:0] t, flags_type f);
      entry_type e;
      e.mn = m; e.len = l; e.base = b; e.taken = t; e.fl = f;
      return e;
   endfunction

   function automatic entry_type unk();
      return mk(MN_UNKNOWN, 2'd1, 5'd4, 5'd4, F_NO);
   endfunction

   // Opcodes 0x00 to 0x3F.
   function automatic entry_type low_entry(logic [5:0] op);
      entry_type e;
      e = unk();
      case (op)
         6'h00: e = mk(MN_NOP, 2'd1, 5'd4, 5'd4, F_NO);
         6'h01, 6'h11, 6'h21, 6'h31: e = mk(MN_LD, 2'd3, 5'd12, 5'd12, F_NO);
         6'h02, 6'h12, 6'h22, 6'h32, 6'h0A, 6'h1A, 6'h2A, 6'h3A:
            e = mk(MN_LD, 2'd1, 5'd8, 5'd8, F_NO);
         6'h03, 6'h13, 6'h23, 6'h33: e = mk(MN_INC, 2'd1, 5'd8, 5'd8, F_NO);
         6'h0B, 6'h1B, 6'h2B, 6'h3B: e = mk(MN_DEC, 2'd1, 5'd8, 5'd8, F_NO);
         6'h04, 6'h14, 6'h24, 6'h0C, 6'h1C, 6'h2C, 6'h3C:
            e = mk(MN_INC, 2'd1, 5'd4, 5'd4, F_INC);
         6'h05, 6'h15, 6'h25, 6'h0D, 6'h1D, 6'h2D, 6'h3D:
            e = mk(MN_DEC, 2'd1, 5'd4, 5'd4, F_DEC);
         6'h34: e = mk(MN_INC, 2'd1, 5'd12, 5'd12, F_INC);
         6'h35: e = mk(MN_DEC, 2'd1, 5'd12, 5'd12, F_DEC);
         6'h06, 6'h16, 6'h26, 6'h0E, 6'h1E, 6'h2E, 6'h3E:
            e = mk(MN_LD, 2'd2, 5'd8, 5'd8, F_NO);
         6'h36: e = mk(MN_LD, 2'd2, 5'd12, 5'd12, F_NO);
         6'h07: e = mk(MN_RLCA, 2'd1, 5'd4, 5'd4, F_ROTA);
         6'h0F: e = mk(MN_RRCA, 2'd1, 5'd4, 5'd4, F_ROTA);
         6'h17: e = mk(MN_RLA, 2'd1, 5'd4, 5'd4, F_ROTA);
         6'h1F: e = mk(MN_RRA, 2'd1, 5'd4, 5'd4, F_ROTA);
         6'h27: e = mk(MN_DAA, 2'd1, 5'd4, 5'd4, F_DAA);
         6'h2F: e = mk(MN_CPL, 2'd1, 5'd4, 5'd4, F_CPL);
         6'h37: e = mk(MN_SCF, 2'd1, 5'd4, 5'd4, F_SCF);
         6'h3F: e = mk(MN_CCF, 2'd1, 5'd4, 5'd4, F_CCF);
         6'h08: e = mk(MN_LD, 2'd3, 5'd20, 5'd20, F_NO);
         6'h09, 6'h19, 6'h29, 6'h39: e = mk(MN_ADD, 2'd1, 5'd8, 5'd8, F_ADDHL);
         6'h10: e = mk(MN_STOP, 2'd2, 5'd4, 5'd4, F_NO);
         6'h18: e = mk(MN_JR, 2'd2, 5'd12, 5'd12, F_NO);
         6'h20, 6'h28, 6'h30, 6'h38: e = mk(MN_JR, 2'd2, 5'd8, 5'd12, F_NO);
         default: e = unk();
      endcase
      return e;
   endfunction

   // Opcodes 0xC0 to 0xFF, without the prefix slot.
   function automatic entry_type high_entry(logic [5:0] op);
      entry_type e;
      e = unk();
      case (op)
         6'h00, 6'h08, 6'h10, 6'h18: e = mk(MN_RET, 2'd1, 5'd8, 5'd20, F_NO);
         6'h09: e = mk(MN_RET, 2'd1, 5'd16, 5'd16, F_NO);
         6'h19: e = mk(MN_RETI, 2'd1, 5'd16, 5'd16, F_NO);
         6'h01, 6'h11, 6'h21, 6'h31: e = mk(MN_POP, 2'd1, 5'd12, 5'd12, F_NO);
         6'h05, 6'h15, 6'h25, 6'h35: e = mk(MN_PUSH, 2'd1, 5'd16, 5'd16, F_NO);
         6'h02, 6'h0A, 6'h12, 6'h1A: e = mk(MN_JP, 2'd3, 5'd12, 5'd16, F_NO);
         6'h03: e = mk(MN_JP, 2'd3, 5'd16, 5'd16, F_NO);
         6'h29: e = mk(MN_JP, 2'd1, 5'd4, 5'd4, F_NO);
         6'h04, 6'h0C, 6'h14, 6'h1C: e = mk(MN_CALL, 2'd3, 5'd12, 5'd24, F_NO);
         6'h0D: e = mk(MN_CALL, 2'd3, 5'd24, 5'd24, F_NO);
         6'h07, 6'h0F, 6'h17, 6'h1F, 6'h27, 6'h2F, 6'h37, 6'h3F:
            e = mk(MN_RST, 2'd1, 5'd16, 5'd16, F_NO);
         6'h06: e = mk(MN_ADD, 2'd2, 5'd8, 5'd8, F_ALUA);
         6'h0E: e = mk(MN_ADC, 2'd2, 5'd8, 5'd8, F_ALUA);
         6'h16: e = mk(MN_SUB, 2'd2, 5'd8, 5'd8, F_ALUS);
         6'h1E: e = mk(MN_SBC, 2'd2, 5'd8, 5'd8, F_ALUS);
         6'h26: e = mk(MN_AND, 2'd2, 5'd8, 5'd8, F_AND);
         6'h2E: e = mk(MN_XOR, 2'd2, 5'd8, 5'd8, F_OR);
         6'h36: e = mk(MN_OR, 2'd2, 5'd8, 5'd8, F_OR);
         6'h3E: e = mk(MN_CP, 2'd2, 5'd8, 5'd8, F_ALUS);
         6'h20, 6'h30: e = mk(MN_LDH, 2'd2, 5'd12, 5'd12, F_NO);
         6'h22, 6'h32: e = mk(MN_LD, 2'd1, 5'd8, 5'd8, F_NO);
         6'h39: e = mk(MN_LD, 2'd1, 5'd8, 5'd8, F_NO);
         6'h2A, 6'h3A: e = mk(MN_LD, 2'd3, 5'd16, 5'd16, F_NO);
         6'h28: e = mk(MN_ADD, 2'd2, 5'd16, 5'd16, F_SP);
         6'h38: e = mk(MN_LD, 2'd2, 5'd12, 5'd12, F_SP);
         6'h33: e = mk(MN_DI, 2'd1, 5'd4, 5'd4, F_NO);
         6'h3B: e = mk(MN_EI, 2'd1, 5'd4, 5'd4, F_NO);
         default: e = unk();
      endcase
      return e;
   endfunction

endpackage

// File: hw/rtl/sm83_opcode_predecoder.sv
// SM83 opcode predecoder top level: one registered decode pass.
// Depends on sm83_pkg for the opcode tables and codes.
//
// Usage: drive req_* with up to three instruction bytes and the count of
// valid ones, and pulse start. A transaction is accepted at a clock edge with
// start high and busy low; busy is always low, so one transaction can be
// accepted every cycle. The bytes are captured in an input register, decoded
// by table logic, and the result lands in an output register at the next
// edge, where rsp_valid is high for exactly one cycle. Throughput is one
// transaction per cycle, set by the single decode stage between the two
// registers. The receiver cannot hold results off and must take each one in
// the cycle it is shown. The third byte is not registered and does not
// affect the decode.
// Synchronous reset clears the valid bits of both registers; no transaction
// is lost or repeated in flight afterwards; the data registers are not reset.
module sm83_opcode_predecoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_first_byte,
   input  logic [7:0] req_second_byte,
   input  logic [7:0] req_third_byte,
   input  logic [1:0] req_bytes_available,
   output logic       rsp_valid,
   output logic [5:0] rsp_mnemonic_code,
   output logic [1:0] rsp_instr_length,
   output logic [4:0] rsp_base_cycles,
   output logic [4:0] rsp_taken_cycles,
   output logic [1:0] rsp_zero_flag_effect,
   output logic [1:0] rsp_subtract_flag_effect,
   output logic [1:0] rsp_half_carry_effect,
   output logic [1:0] rsp_carry_flag_effect,
   output logic [2:0] rsp_prefixed_register,
   output logic [2:0] rsp_prefixed_bit
);
   import sm83_pkg::*;

   logic       stage_valid_ff;
   logic [7:0] first_ff, second_ff;
   logic [1:0] avail_ff;
   logic       out_valid_ff;
   entry_type  entry_ff, entry_in;
   logic [2:0] preg_ff, preg_in, pbit_ff, pbit_in;
   logic [2:0] sreg, sgrp;
   logic [4:0] pcyc;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= start;
         out_valid_ff   <= stage_valid_ff;
      end
      first_ff  <= req_first_byte;
      second_ff <= req_second_byte;
      avail_ff  <= req_bytes_available;
      entry_ff  <= entry_in;
      preg_ff   <= preg_in;
      pbit_ff   <= pbit_in;
   end

   assign sreg = second_ff[2:0];
   assign sgrp = second_ff[5:3];
   assign pcyc = (sreg == REG_HL) ? 5'd16 : 5'd8;

   always_comb begin
      entry_in = unk();
      preg_in  = 3'd0;
      pbit_in  = 3'd0;
      case (first_ff[7:6])
         2'b00: entry_in = low_entry(first_ff[5:0]);
         2'b01: begin
            if (first_ff == OP_HALT) begin
               entry_in = mk(MN_HALT, 2'd1, 5'd4, 5'd4, F_NO);
            end else if (first_ff[2:0] == REG_HL || first_ff[5:3] == REG_HL) begin
               entry_in = mk(MN_LD, 2'd1, 5'd8, 5'd8, F_NO);
            end else begin
               entry_in = mk(MN_LD, 2'd1, 5'd4, 5'd4, F_NO);
            end
         end
         2'b10: begin
            entry_in = mk(MN_ADD, 2'd1, (first_ff[2:0] == REG_HL) ? 5'd8 : 5'd4,
                          (first_ff[2:0] == REG_HL) ? 5'd8 : 5'd4, F_ALUA);
            case (first_ff[5:3])
               3'd0: begin entry_in.mn = MN_ADD; entry_in.fl = F_ALUA; end
               3'd1: begin entry_in.mn = MN_ADC; entry_in.fl = F_ALUA; end
               3'd2: begin entry_in.mn = MN_SUB; entry_in.fl = F_ALUS; end
               3'd3: begin entry_in.mn = MN_SBC; entry_in.fl = F_ALUS; end
               3'd4: begin entry_in.mn = MN_AND; entry_in.fl = F_AND; end
               3'd5: begin entry_in.mn = MN_XOR; entry_in.fl = F_OR; end
               3'd6: begin entry_in.mn = MN_OR;  entry_in.fl = F_OR; end
               default: begin entry_in.mn = MN_CP; entry_in.fl = F_ALUS; end
            endcase
         end
         default: begin
            if (first_ff == OP_PREFIX) begin
               if (avail_ff > 2'd1) begin
                  preg_in = sreg;
                  case (second_ff[7:6])
                     2'b00: entry_in = mk(mnemonic_type'(6'(MN_RLC) + 6'(sgrp)), 2'd2,
                                          pcyc, pcyc,
                                          (sgrp == GRP_SWAP) ? F_SWAP : F_SHIFT);
                     2'b01: begin
                        entry_in = mk(MN_BIT, 2'd2, (sreg == REG_HL) ? 5'd12 : 5'd8,
                                      (sreg == REG_HL) ? 5'd12 : 5'd8, F_BIT);
                        pbit_in = sgrp;
                     end
                     2'b10: begin
                        entry_in = mk(MN_RES, 2'd2, pcyc, pcyc, F_NO);
                        pbit_in = sgrp;
                     end
                     default: begin
                        entry_in = mk(MN_SET, 2'd2, pcyc, pcyc, F_NO);
                        pbit_in = sgrp;
                     end
                  endcase
               end
            end else begin
               entry_in = high_entry(first_ff[5:0]);
            end
         end
      endcase
   end

   assign rsp_valid                = out_valid_ff;
   assign rsp_mnemonic_code        = entry_ff.mn;
   assign rsp_instr_length         = entry_ff.len;
   assign rsp_base_cycles          = entry_ff.base;
   assign rsp_taken_cycles         = entry_ff.taken;
   assign rsp_zero_flag_effect     = entry_ff.fl.z;
   assign rsp_subtract_flag_effect = entry_ff.fl.n;
   assign rsp_half_carry_effect    = entry_ff.fl.h;
   assign rsp_carry_flag_effect    = entry_ff.fl.c;
   assign rsp_prefixed_register    = preg_ff;
   assign rsp_prefixed_bit         = pbit_ff;

endmodule
